FILE: hw/rtl/text_console_cell_writer_defines.svh
// Assertion macros for the text console cell writer.
// Used by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH

`ifndef SYNTH
`define TCCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCCW_ASSERT(lbl, prop, msg)
`define TCCW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/tccw_pkg.sv
// Shared constants, types and helpers for the text console cell writer.
// No dependencies; imported by tccw_if, tccw_addr_unit, tccw_ctrl and the top level.
package tccw_pkg;

  localparam int MAX_COLS  = 80;
  localparam int MEM_ROWS  = 64;
  localparam int CELLS     = MAX_COLS * MEM_ROWS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int ROW_W     = $clog2(MEM_ROWS);
  localparam int COL_IDX_W = $clog2(MAX_COLS);
  localparam int ROWCNT_W  = $clog2(MEM_ROWS + 1);
  localparam int COLCNT_W  = $clog2(MAX_COLS + 1);

  localparam int CMD_W     = 3;
  localparam int BYTE_W    = 8;
  localparam int CUR_COL_W = 7;
  localparam int CUR_ROW_W = 6;
  localparam int CELL_ROW_W = 6;
  localparam int CELL_COL_W = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0]    NEWLINE    = 8'd10;
  localparam logic [BYTE_W-1:0]    ATTR_RESET = 8'h07;
  localparam logic [CFG_W-1:0]     COLS_RESET = 7'd80;
  localparam logic [CFG_W-1:0]     ROWS_RESET = 7'd25;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 3'd0,
    CMD_BS    = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_ATTR  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_BS_ADDR,
    ST_BS_WAIT,
    ST_BS_CHK,
    ST_RD_WAIT,
    ST_RD_DATA,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_IDX_W-1:0] col;
    logic                 chr_we;
    logic                 atr_we;
    logic [BYTE_W-1:0]    chr_wd;
    logic [BYTE_W-1:0]    atr_wd;
  } mem_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              chr_we;
    logic              atr_we;
    logic [BYTE_W-1:0] chr_wd;
    logic [BYTE_W-1:0] atr_wd;
  } mem_cmd_t;

  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
    return (r == ROW_W'(MEM_ROWS - 1)) ? '0 : r + ROW_W'(1);
  endfunction

endpackage

FILE: hw/rtl/tccw_if.sv
// Channel interfaces of the text console cell writer: command in, status out, config.
// Depends on tccw_pkg.
interface tccw_in_if
  import tccw_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [BYTE_W-1:0]     char_code;
  logic [BYTE_W-1:0]     attr;
  logic [CELL_ROW_W-1:0] cell_row;
  logic [CELL_COL_W-1:0] cell_col;

  modport source (output valid, cmd, char_code, attr, cell_row, cell_col, input ready);
  modport sink   (input valid, cmd, char_code, attr, cell_row, cell_col, output ready);
endinterface

interface tccw_out_if
  import tccw_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CUR_COL_W-1:0] cursor_col;
  logic [CUR_ROW_W-1:0] cursor_row;
  logic [CUR_ROW_W-1:0] scroll_row;
  logic [BYTE_W-1:0]    read_char;
  logic [BYTE_W-1:0]    read_attr;

  modport source (output valid, cursor_col, cursor_row, scroll_row, read_char, read_attr,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, scroll_row, read_char, read_attr,
                  output ready);
endinterface

interface tccw_cfg_if
  import tccw_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/tccw_ram.sv
// Single-port RAM with registered read data, one write or read per cycle.
// No package dependency.
module tccw_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  input  logic              we,
  input  logic [DATA_W-1:0] wd,
  output logic [DATA_W-1:0] rd
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    rd <= mem[addr];
  end

endmodule

FILE: hw/rtl/tccw_addr_unit.sv
// Shared cell address unit: row * MAX_COLS + col, registered with the write request.
// Depends on tccw_pkg.
module tccw_addr_unit
  import tccw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output mem_cmd_t cmd
);

  logic [ADDR_W-1:0] addr_r;
  logic [BYTE_W-1:0] chr_wd_r;
  logic [BYTE_W-1:0] atr_wd_r;
  logic              chr_we_r;
  logic              atr_we_r;

  always_ff @(posedge clk) begin
    addr_r   <= ADDR_W'(req.row) * ADDR_W'(MAX_COLS) + ADDR_W'(req.col);
    chr_wd_r <= req.chr_wd;
    atr_wd_r <= req.atr_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chr_we_r <= 1'b0;
      atr_we_r <= 1'b0;
    end else begin
      chr_we_r <= req.chr_we;
      atr_we_r <= req.atr_we;
    end
  end

  assign cmd = '{addr: addr_r, chr_we: chr_we_r, atr_we: atr_we_r,
                 chr_wd: chr_wd_r, atr_wd: atr_wd_r};

endmodule

FILE: hw/rtl/tccw_ctrl.sv
// Command sequencer: cursor, scroll, attribute and config state, store sweeps and scans.
// Depends on tccw_pkg, tccw_if and text_console_cell_writer_defines.svh.
`include "text_console_cell_writer_defines.svh"

module tccw_ctrl
  import tccw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  tccw_in_if.sink           in_ch,
  tccw_out_if.source        out_ch,
  tccw_cfg_if.sink          cfg_ch,
  output mem_req_t          req,
  input  logic [BYTE_W-1:0] chr_rdata,
  input  logic [BYTE_W-1:0] atr_rdata
);

  st_t state_r, state_nxt;

  logic [CUR_COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]     cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0]     scroll_r, scroll_nxt;
  logic [BYTE_W-1:0]    attr_r, attr_nxt;
  logic [CFG_W-1:0]     cols_r, rows_r;
  logic                 init_r, init_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [ROW_W-1:0]     sw_row_r, sw_row_nxt;
  logic [COL_IDX_W-1:0] sw_col_r, sw_col_nxt;
  logic [ROWCNT_W-1:0]  sw_rows_r, sw_rows_nxt;
  logic [COLCNT_W-1:0]  sw_cols_r, sw_cols_nxt;
  logic                 sw_chr_r, sw_chr_nxt;
  logic                 sw_atr_r, sw_atr_nxt;
  logic [BYTE_W-1:0]    sw_val_r, sw_val_nxt;
  logic [BYTE_W-1:0]    rd_chr_r, rd_chr_nxt;
  logic [BYTE_W-1:0]    rd_atr_r, rd_atr_nxt;

  logic [CUR_COL_W-1:0] out_col_r, out_col_nxt;
  logic [CUR_ROW_W-1:0] out_row_r, out_row_nxt;
  logic [CUR_ROW_W-1:0] out_scr_r, out_scr_nxt;
  logic [BYTE_W-1:0]    out_chr_r, out_chr_nxt;
  logic [BYTE_W-1:0]    out_atr_r, out_atr_nxt;

  logic                 in_acc;
  logic [COLCNT_W-1:0]  eff_cols;
  logic [ROWCNT_W-1:0]  eff_rows;
  logic [ROW_W-1:0]     row_n;
  logic [ROW_W-1:0]     nl_scroll;
  logic [CUR_COL_W:0]   col_p1;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.scroll_row = out_scr_r;
  assign out_ch.read_char  = out_chr_r;
  assign out_ch.read_attr  = out_atr_r;

  always_comb begin
    if (cols_r == '0) begin
      eff_cols = COLCNT_W'(1);
    end else if (int'(cols_r) > MAX_COLS) begin
      eff_cols = COLCNT_W'(MAX_COLS);
    end else begin
      eff_cols = COLCNT_W'(cols_r);
    end
    if (int'(rows_r) > MEM_ROWS) begin
      eff_rows = ROWCNT_W'(MEM_ROWS);
    end else begin
      eff_rows = ROWCNT_W'(rows_r);
    end
  end

  assign row_n     = row_inc(cur_row_r);
  assign nl_scroll = (int'(row_n) >= int'(rows_r)) ? row_inc(scroll_r) : scroll_r;
  assign col_p1    = {1'b0, cur_col_r} + (CUR_COL_W+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      scroll_r    <= '0;
      attr_r      <= ATTR_RESET;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      scroll_r    <= scroll_nxt;
      attr_r      <= attr_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_COLS: cols_r <= cfg_ch.data;
        REG_ROWS: rows_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sw_row_r  <= sw_row_nxt;
    sw_col_r  <= sw_col_nxt;
    sw_rows_r <= sw_rows_nxt;
    sw_cols_r <= sw_cols_nxt;
    sw_chr_r  <= sw_chr_nxt;
    sw_atr_r  <= sw_atr_nxt;
    sw_val_r  <= sw_val_nxt;
    rd_chr_r  <= rd_chr_nxt;
    rd_atr_r  <= rd_atr_nxt;
    out_col_r <= out_col_nxt;
    out_row_r <= out_row_nxt;
    out_scr_r <= out_scr_nxt;
    out_chr_r <= out_chr_nxt;
    out_atr_r <= out_atr_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    scroll_nxt    = scroll_r;
    attr_nxt      = attr_r;
    init_nxt      = init_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    sw_row_nxt    = sw_row_r;
    sw_col_nxt    = sw_col_r;
    sw_rows_nxt   = sw_rows_r;
    sw_cols_nxt   = sw_cols_r;
    sw_chr_nxt    = sw_chr_r;
    sw_atr_nxt    = sw_atr_r;
    sw_val_nxt    = sw_val_r;
    rd_chr_nxt    = rd_chr_r;
    rd_atr_nxt    = rd_atr_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_scr_nxt   = out_scr_r;
    out_chr_nxt   = out_chr_r;
    out_atr_nxt   = out_atr_r;
    req           = '0;
    req.row       = cur_row_r;

    case (state_r)
      ST_INIT: begin
        sw_row_nxt  = '0;
        sw_col_nxt  = '0;
        sw_rows_nxt = ROWCNT_W'(MEM_ROWS);
        sw_cols_nxt = COLCNT_W'(MAX_COLS);
        sw_chr_nxt  = 1'b1;
        sw_atr_nxt  = 1'b1;
        sw_val_nxt  = '0;
        state_nxt   = ST_SWEEP;
      end

      ST_IDLE: begin
        if (in_acc) begin
          rd_chr_nxt = '0;
          rd_atr_nxt = '0;
          state_nxt  = ST_DONE;
          case (cmd_t'(in_ch.cmd))
            CMD_PUT: begin
              if (in_ch.char_code == NEWLINE) begin
                cur_col_nxt = '0;
                cur_row_nxt = row_n;
                scroll_nxt  = nl_scroll;
              end else begin
                // past the last column the character lands at the start of the next row
                if (int'(cur_col_r) >= int'(eff_cols)) begin
                  req.row = row_n;
                  req.col = '0;
                end else begin
                  req.col = COL_IDX_W'(cur_col_r);
                end
                req.chr_we = 1'b1;
                req.atr_we = 1'b1;
                req.chr_wd = in_ch.char_code;
                req.atr_wd = attr_r;
                if (int'(col_p1) >= int'(eff_cols)) begin
                  cur_col_nxt = '0;
                  cur_row_nxt = row_n;
                  scroll_nxt  = nl_scroll;
                end else begin
                  cur_col_nxt = col_p1[CUR_COL_W-1:0];
                end
              end
            end
            CMD_BS: begin
              if (cur_col_r != '0) begin
                req.col     = COL_IDX_W'(cur_col_r - CUR_COL_W'(1));
                req.chr_we  = 1'b1;
                cur_col_nxt = cur_col_r - CUR_COL_W'(1);
              end else if (cur_row_r != '0) begin
                cur_row_nxt = cur_row_r - ROW_W'(1);
                cur_col_nxt = CUR_COL_W'(eff_cols);
                state_nxt   = ST_BS_ADDR;
              end
            end
            CMD_CLEAR: begin
              cur_col_nxt = '0;
              cur_row_nxt = '0;
              sw_row_nxt  = '0;
              sw_col_nxt  = '0;
              sw_rows_nxt = eff_rows;
              sw_cols_nxt = eff_cols;
              sw_chr_nxt  = 1'b1;
              sw_atr_nxt  = 1'b0;
              sw_val_nxt  = '0;
              if (eff_rows != '0) begin
                state_nxt = ST_SWEEP;
              end
            end
            CMD_ATTR: begin
              attr_nxt    = in_ch.attr;
              sw_row_nxt  = '0;
              sw_col_nxt  = '0;
              sw_rows_nxt = eff_rows;
              sw_cols_nxt = eff_cols;
              sw_chr_nxt  = 1'b0;
              sw_atr_nxt  = 1'b1;
              sw_val_nxt  = in_ch.attr;
              if (eff_rows != '0) begin
                state_nxt = ST_SWEEP;
              end
            end
            CMD_READ: begin
              if (int'(in_ch.cell_row) < MEM_ROWS && int'(in_ch.cell_col) < MAX_COLS) begin
                req.row   = ROW_W'(in_ch.cell_row);
                req.col   = COL_IDX_W'(in_ch.cell_col);
                state_nxt = ST_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SWEEP: begin
        req.row    = sw_row_r;
        req.col    = sw_col_r;
        req.chr_we = sw_chr_r;
        req.atr_we = sw_atr_r;
        req.chr_wd = sw_val_r;
        req.atr_wd = sw_val_r;
        if (int'(sw_col_r) + 1 == int'(sw_cols_r)) begin
          sw_col_nxt = '0;
          if (int'(sw_row_r) + 1 == int'(sw_rows_r)) begin
            state_nxt = init_r ? ST_IDLE : ST_DONE;
            init_nxt  = 1'b0;
          end else begin
            sw_row_nxt = sw_row_r + ROW_W'(1);
          end
        end else begin
          sw_col_nxt = sw_col_r + COL_IDX_W'(1);
        end
      end

      ST_BS_ADDR: begin
        if (cur_col_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          req.col   = COL_IDX_W'(cur_col_r - CUR_COL_W'(1));
          state_nxt = ST_BS_WAIT;
        end
      end

      ST_BS_WAIT: state_nxt = ST_BS_CHK;

      ST_BS_CHK: begin
        if (chr_rdata == '0) begin
          cur_col_nxt = cur_col_r - CUR_COL_W'(1);
          state_nxt   = ST_BS_ADDR;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_RD_WAIT: state_nxt = ST_RD_DATA;

      ST_RD_DATA: begin
        rd_chr_nxt = chr_rdata;
        rd_atr_nxt = atr_rdata;
        state_nxt  = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = cur_col_r;
          out_row_nxt   = CUR_ROW_W'(cur_row_r);
          out_scr_nxt   = CUR_ROW_W'(scroll_r);
          out_chr_nxt   = rd_chr_r;
          out_atr_nxt   = rd_atr_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  `TCCW_ASSERT_ALWAYS(a_rst_no_out, !rst_n |=> !out_valid_r, "result valid after reset")
  `TCCW_ASSERT(a_no_acc_in_init, in_acc |-> !init_r, "transaction accepted during store init")
  `TCCW_ASSERT(a_one_at_a_time, in_acc |=> !in_ch.ready, "ready while a command is in work")
  `TCCW_ASSERT(a_cursor_bound, out_valid_r |-> (int'(out_col_r) <= MAX_COLS), "cursor col out of range")
  `TCCW_ASSERT(a_sweep_bound, (state_r == ST_SWEEP) |-> (int'(sw_row_r) < int'(sw_rows_r)), "sweep row overrun")
  `TCCW_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == ST_DONE), "result not from done state")

endmodule

FILE: hw/rtl/text_console_cell_writer.sv
// Text console cell writer: a 64 x 80 store of character and attribute bytes behind a
// small sequencer that shares one cell address unit. After reset the store is zeroed by a
// clearing pass (one setup step, then one cell a cycle) during which no command is taken;
// config writes are taken at any time. The result of a put char, newline, plain backspace
// or unknown command passes the done state into the output register, that of a cell read
// goes through address, RAM read and capture first. Clear screen and set attribute write
// one cell a cycle through the address unit over the visible rows and columns. A backspace
// at column 0 scans back over empty cells through the single RAM read port, with address,
// wait and check states for each cell checked. One command is in work at a time;
// the result sits in an output register, and the next command can be taken in the cycle in
// which the result is valid; a stalled output holds the sequencer in its done state.
module text_console_cell_writer
  import tccw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tccw_in_if.sink    in_ch,
  tccw_out_if.source out_ch,
  tccw_cfg_if.sink   cfg_ch
);

  mem_req_t          req;
  mem_cmd_t          cmd;
  logic [BYTE_W-1:0] chr_rdata;
  logic [BYTE_W-1:0] atr_rdata;

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .req       (req),
    .chr_rdata (chr_rdata),
    .atr_rdata (atr_rdata)
  );

  tccw_addr_unit u_addr (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .cmd   (cmd)
  );

  tccw_ram #(.DEPTH(CELLS), .DATA_W(BYTE_W), .ADDR_W(ADDR_W)) u_chr_ram (
    .clk  (clk),
    .addr (cmd.addr),
    .we   (cmd.chr_we),
    .wd   (cmd.chr_wd),
    .rd   (chr_rdata)
  );

  tccw_ram #(.DEPTH(CELLS), .DATA_W(BYTE_W), .ADDR_W(ADDR_W)) u_atr_ram (
    .clk  (clk),
    .addr (cmd.addr),
    .we   (cmd.atr_we),
    .wd   (cmd.atr_wd),
    .rd   (atr_rdata)
  );

endmodule
